// File: src/srfp_pkg.sv
package srfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int PHASE_W   = 4;
    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hFB;
    localparam logic [BYTE_W-1:0] FC_HOMING   = 8'h91;
    localparam logic [BYTE_W-1:0] FC_SETZERO  = 8'h92;
    localparam logic [BYTE_W-1:0] FC_POSITION = 8'h31;
    localparam logic [BYTE_W-1:0] ADDR_RESET  = 8'h03;

    localparam logic [BYTE_W-1:0] ST_FAIL        = 8'd0;
    localparam logic [BYTE_W-1:0] ST_SETZERO_OK  = 8'd1;
    localparam logic [BYTE_W-1:0] ST_HOMING_OK   = 8'd2;

    localparam logic [PHASE_W-1:0] PH_HUNT        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ADDR        = 4'd1;
    localparam logic [PHASE_W-1:0] PH_FUNC        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CHECK_SHORT = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CHECK_POS   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED   = 2'd1;

    typedef enum logic [1:0] {
        REPLY_HOMING   = 2'd0,
        REPLY_SETZERO  = 2'd1,
        REPLY_POSITION = 2'd2,
        REPLY_NONE     = 2'd3
    } reply_t;

    typedef enum logic [1:0] {
        OUTCOME_OK   = 2'd0,
        OUTCOME_FAIL = 2'd1,
        OUTCOME_POS  = 2'd2
    } outcome_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [BYTE_W-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              outcome;
        logic signed [POS_W-1:0] position;
    } result_t;

endpackage

// File: src/servo_reply_frame_parser_core.sv
// channel | signals                          | direction
// in      | in_valid, in_ready, rx_byte      | byte from the servo UART
// out     | out_valid, out_ready, outcome,   | at most one result per frame
//         | position                         |
// cfg     | cfg_valid, cfg_ready, cfg_index, | register writes, always ready
//         | cfg_data                         |
// One item per cycle while the output register can take; a byte is held in the input
// register and parsed as it leaves it, and a result is registered in the output register
// as its checksum byte leaves the input register.
// Reset clears the parser to hunting with slave address 3 and homing reply awaited.
// A full output register with out_ready low stalls parsing; in_ready then drops once
// the input register holds a byte.
module servo_reply_frame_parser_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [srfp_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           outcome,
    output logic signed [srfp_pkg::POS_W-1:0]    position,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srfp_pkg::BYTE_W-1:0]          cfg_data
);

    logic                        item_valid;
    logic [srfp_pkg::BYTE_W-1:0] item_byte;
    logic                        can_take;
    logic                        fire;
    srfp_pkg::cfg_wr_t           cfg;
    srfp_pkg::result_t           res;

    assign cfg_ready = 1'b1;
    assign cfg.wr_en = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign fire      = item_valid && can_take;

    srfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    srfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .item_byte (item_byte),
        .res       (res)
    );

    srfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .outcome   (outcome),
        .position  (position)
    );

endmodule

// File: src/srfp_in_stage.sv
module srfp_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [srfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        advance,
    output logic                        item_valid,
    output logic [srfp_pkg::BYTE_W-1:0] item_byte
);

    logic                        valid_reg;
    logic [srfp_pkg::BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// File: src/srfp_parser.sv
module srfp_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srfp_pkg::cfg_wr_t           cfg,
    input  logic                        fire,
    input  logic [srfp_pkg::BYTE_W-1:0] item_byte,
    output srfp_pkg::result_t           res
);

    logic [srfp_pkg::BYTE_W-1:0]  addr_reg, addr_next;
    srfp_pkg::reply_t             exp_reg, exp_next;
    logic [srfp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [srfp_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic [srfp_pkg::BYTE_W-1:0]  status_reg, status_next;
    logic [srfp_pkg::POS_W-1:0]   pos_reg, pos_next;

    logic [srfp_pkg::PHASE_W-1:0] check_phase;
    logic [srfp_pkg::BYTE_W-1:0]  code;
    logic                         known;
    logic [srfp_pkg::BYTE_W-1:0]  sum_plus;
    logic                         is_pos;

    assign is_pos      = (exp_reg == srfp_pkg::REPLY_POSITION);
    assign check_phase = is_pos ? srfp_pkg::PH_CHECK_POS : srfp_pkg::PH_CHECK_SHORT;
    assign sum_plus    = sum_reg + item_byte;

    always_comb
    begin
        case (exp_reg)
            srfp_pkg::REPLY_HOMING:
            begin
                code  = srfp_pkg::FC_HOMING;
                known = 1'b1;
            end
            srfp_pkg::REPLY_SETZERO:
            begin
                code  = srfp_pkg::FC_SETZERO;
                known = 1'b1;
            end
            srfp_pkg::REPLY_POSITION:
            begin
                code  = srfp_pkg::FC_POSITION;
                known = 1'b1;
            end
            default:
            begin
                code  = '0;
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        addr_next   = addr_reg;
        exp_next    = exp_reg;
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        res         = '0;

        if (cfg.wr_en)
        begin
            // a write to the slave address or expected reply register restarts the hunt
            if (cfg.index == srfp_pkg::REG_SLAVE_ADDR)
            begin
                addr_next  = cfg.data;
                phase_next = srfp_pkg::PH_HUNT;
                sum_next   = '0;
            end
            else if (cfg.index == srfp_pkg::REG_EXPECTED)
            begin
                exp_next   = srfp_pkg::reply_t'(cfg.data[1:0]);
                phase_next = srfp_pkg::PH_HUNT;
                sum_next   = '0;
            end
        end
        else if (fire)
        begin
            if (phase_reg == srfp_pkg::PH_HUNT || phase_reg > check_phase)
            begin
                if (item_byte == srfp_pkg::HDR_BYTE)
                begin
                    sum_next   = item_byte;
                    phase_next = srfp_pkg::PH_ADDR;
                end
                else
                begin
                    sum_next   = '0;
                    phase_next = srfp_pkg::PH_HUNT;
                end
            end
            else if (phase_reg == srfp_pkg::PH_ADDR)
            begin
                if (item_byte != addr_reg)
                begin
                    sum_next   = '0;
                    phase_next = srfp_pkg::PH_HUNT;
                end
                else
                begin
                    sum_next   = sum_plus;
                    phase_next = srfp_pkg::PH_FUNC;
                end
            end
            else if (phase_reg == srfp_pkg::PH_FUNC)
            begin
                if (!known || item_byte != code)
                begin
                    sum_next   = '0;
                    phase_next = srfp_pkg::PH_HUNT;
                end
                else
                begin
                    sum_next   = sum_plus;
                    phase_next = srfp_pkg::PH_PAYLOAD;
                end
            end
            else if (phase_reg < check_phase)
            begin
                sum_next   = sum_plus;
                phase_next = phase_reg + 4'd1;
                if (is_pos)
                begin
                    pos_next = {pos_reg[srfp_pkg::POS_W-srfp_pkg::BYTE_W-1:0], item_byte};
                end
                else
                begin
                    status_next = item_byte;
                end
            end
            else
            begin
                // checksum byte
                sum_next   = '0;
                phase_next = srfp_pkg::PH_HUNT;
                if (item_byte == sum_reg)
                begin
                    if (is_pos)
                    begin
                        res.valid    = 1'b1;
                        res.outcome  = srfp_pkg::OUTCOME_POS;
                        res.position = pos_reg;
                    end
                    else if (status_reg == srfp_pkg::ST_FAIL)
                    begin
                        res.valid   = 1'b1;
                        res.outcome = srfp_pkg::OUTCOME_FAIL;
                    end
                    else if ((exp_reg == srfp_pkg::REPLY_HOMING &&
                              status_reg == srfp_pkg::ST_HOMING_OK) ||
                             (exp_reg == srfp_pkg::REPLY_SETZERO &&
                              status_reg == srfp_pkg::ST_SETZERO_OK))
                    begin
                        res.valid   = 1'b1;
                        res.outcome = srfp_pkg::OUTCOME_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= srfp_pkg::ADDR_RESET;
            exp_reg    <= srfp_pkg::REPLY_HOMING;
            phase_reg  <= srfp_pkg::PH_HUNT;
            sum_reg    <= '0;
            status_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            addr_reg   <= addr_next;
            exp_reg    <= exp_next;
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// File: src/srfp_out_stage.sv
module srfp_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  srfp_pkg::result_t                 res,
    output logic                              can_take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        outcome,
    output logic signed [srfp_pkg::POS_W-1:0] position
);

    logic                              valid_reg;
    logic [1:0]                        outcome_reg;
    logic signed [srfp_pkg::POS_W-1:0] position_reg;

    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign outcome   = outcome_reg;
    assign position  = position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= load && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && load && res.valid)
        begin
            outcome_reg  <= res.outcome;
            position_reg <= res.position;
        end
    end

endmodule
